// ===== rtl/psd_pkg.sv =====
// Shared types, operation codes and constants for the particle surface detector.
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

    typedef logic signed [31:0] t_word;
    typedef t_word [2:0] t_vec3;
    typedef t_word [5:0] t_sym6;

    typedef enum logic [1:0] {
        OP_SELF_SHAPE  = 2'd0,
        OP_SELF_MOMENT = 2'd1,
        OP_NEIGHBOR    = 2'd2,
        OP_FINISH      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RANGE     = 2'd1,
        REG_COS_SWEEP = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_CONE,
        CS_DECIDE
    } t_core_state;

    typedef enum logic [3:0] {
        CK_DOT0, CK_DOT1, CK_DOT2,
        CK_MM0, CK_MM1, CK_MM2,
        CK_RR0, CK_RR1, CK_RR2,
        CK_DD, CK_CC, CK_CMM, CK_PLO, CK_PHI, CK_RNG
    } t_cone_step;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_psd_status;

    localparam int DIMS   = 3;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [30:0]        THRESHOLD_RESET = 31'd6554;
    localparam logic [30:0]        RANGE_RESET     = 31'd65536;
    localparam logic signed [16:0] COS_RESET       = 17'sd23170;
    localparam logic signed [32:0] ONE_Q16         = 33'sd65536;

    // Element of the packed symmetric tensor for a given row and column.
    function automatic logic [2:0] sym_index(input logic [1:0] row, input logic [1:0] col);
        logic [2:0] idx;
        case ({row, col})
            4'b00_00: idx = 3'd0;
            4'b00_01: idx = 3'd1;
            4'b00_10: idx = 3'd2;
            4'b01_00: idx = 3'd1;
            4'b01_01: idx = 3'd3;
            4'b01_10: idx = 3'd4;
            4'b10_00: idx = 3'd2;
            4'b10_01: idx = 3'd4;
            4'b10_10: idx = 3'd5;
            default:  idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/psd_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module psd_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [psd_pkg::MUL_W-1:0]     i_a,
    input  wire logic signed [psd_pkg::MUL_W-1:0]     i_b,
    output logic signed [psd_pkg::PROD_W-1:0]         o_prod
);
    import psd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== rtl/psd_core.sv =====
// Sequencer and datapath for the neighbor test, built around one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module psd_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire psd_pkg::t_vec3           i_nbr_pos,
    input  wire psd_pkg::t_sym6           i_nbr_shape,
    input  wire psd_pkg::t_vec3           i_self_pos,
    input  wire psd_pkg::t_sym6           i_self_shape,
    input  wire psd_pkg::t_vec3           i_self_m1,
    input  wire logic [30:0]              i_range,
    input  wire logic signed [16:0]       i_cos,
    output psd_pkg::t_psd_status          o_status
);
    import psd_pkg::*;

    t_core_state r_state, n_state;
    logic        r_phase;
    logic        r_t;
    logic [1:0]  r_j;
    logic [1:0]  r_c;
    t_cone_step  r_k;

    logic signed [32:0] r_r [3];
    t_sym6              r_hn;
    logic [31:0]        r_am [3];
    logic               r_asg [3];
    logic [32:0]        r_bm [3];
    logic               r_bsg [3];

    logic signed [66:0] r_acc;
    logic [63:0]        r_tot [2];
    logic signed [32:0] r_d;
    logic [31:0]        r_mm;
    logic [31:0]        r_rr;
    logic [63:0]        r_ll;
    logic [32:0]        r_c2;
    logic [63:0]        r_cmm;
    logic [63:0]        r_plo;
    logic [95:0]        r_rhs;
    logic [61:0]        r_rng2;

    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [PROD_W-1:0] w_p;
    logic signed [32:0]       w_diff [3];
    logic signed [15:0]       w_ra [3];
    logic signed [15:0]       w_rb [3];
    logic                     w_a_big, w_b_big;
    logic signed [50:0]       w_comp;
    logic [50:0]              w_cmag;
    logic [31:0]              w_clamp;
    logic signed [32:0]       w_dneg;
    logic [31:0]              w_dm;
    logic [16:0]              w_cm;
    t_word                    w_h;
    logic                     w_norm_last;
    logic [95:0]              w_lhs;
    logic                     w_cone, w_range_ok;
    logic [63:0]              w_emin;

    psd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_p)
    );

    always_comb begin
        for (int i = 0; i < DIMS; i++) begin
            w_diff[i] = 33'(i_nbr_pos[i]) - 33'(i_self_pos[i]);
            w_ra[i] = r_asg[i] ? -$signed({1'b0, r_am[i][14:0]}) : $signed({1'b0, r_am[i][14:0]});
            w_rb[i] = r_bsg[i] ? -$signed({1'b0, r_bm[i][14:0]}) : $signed({1'b0, r_bm[i][14:0]});
        end
        w_a_big = (r_am[0][31:15] != '0) || (r_am[1][31:15] != '0) || (r_am[2][31:15] != '0);
        w_b_big = (r_bm[0][32:15] != '0) || (r_bm[1][32:15] != '0) || (r_bm[2][32:15] != '0);
    end

    // Scaled component is the row sum floored to Q16.16, then clamped in magnitude.
    always_comb begin
        w_comp  = r_acc[66:16];
        w_cmag  = w_comp[50] ? 51'(-w_comp) : 51'(w_comp);
        w_clamp = (w_cmag > 51'd2147483648) ? 32'h8000_0000 : w_cmag[31:0];
        w_dneg  = -r_d;
        w_dm    = r_d[32] ? w_dneg[31:0] : r_d[31:0];
        w_cm    = i_cos[16] ? 17'(-i_cos) : 17'(i_cos);
        w_h     = r_t ? r_hn[sym_index(r_j, r_c)] : i_self_shape[sym_index(r_j, r_c)];
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        if (r_state == CS_NORM) begin
            if (r_c == 2'(DIMS)) begin
                w_a = MUL_W'(w_clamp);
                w_b = MUL_W'(w_clamp);
            end else begin
                w_a = MUL_W'(w_h);
                w_b = MUL_W'(r_r[r_c]);
            end
        end else if (r_state == CS_CONE) begin
            case (r_k)
                CK_DOT0: begin w_a = MUL_W'(w_ra[0]); w_b = MUL_W'(w_rb[0]); end
                CK_DOT1: begin w_a = MUL_W'(w_ra[1]); w_b = MUL_W'(w_rb[1]); end
                CK_DOT2: begin w_a = MUL_W'(w_ra[2]); w_b = MUL_W'(w_rb[2]); end
                CK_MM0:  begin w_a = MUL_W'(w_ra[0]); w_b = MUL_W'(w_ra[0]); end
                CK_MM1:  begin w_a = MUL_W'(w_ra[1]); w_b = MUL_W'(w_ra[1]); end
                CK_MM2:  begin w_a = MUL_W'(w_ra[2]); w_b = MUL_W'(w_ra[2]); end
                CK_RR0:  begin w_a = MUL_W'(w_rb[0]); w_b = MUL_W'(w_rb[0]); end
                CK_RR1:  begin w_a = MUL_W'(w_rb[1]); w_b = MUL_W'(w_rb[1]); end
                CK_RR2:  begin w_a = MUL_W'(w_rb[2]); w_b = MUL_W'(w_rb[2]); end
                CK_DD:   begin w_a = MUL_W'(w_dm); w_b = MUL_W'(w_dm); end
                CK_CC:   begin w_a = MUL_W'(w_cm); w_b = MUL_W'(w_cm); end
                CK_CMM:  begin w_a = MUL_W'(r_c2); w_b = MUL_W'(r_mm); end
                CK_PLO:  begin w_a = MUL_W'(r_cmm[31:0]); w_b = MUL_W'(r_rr); end
                CK_PHI:  begin w_a = MUL_W'(r_cmm[63:32]); w_b = MUL_W'(r_rr); end
                CK_RNG:  begin w_a = MUL_W'(i_range); w_b = MUL_W'(i_range); end
                default: begin w_a = '0; w_b = '0; end
            endcase
        end
    end

    assign w_norm_last = r_phase && (r_c == 2'(DIMS)) && (r_j == 2'(DIMS - 1)) && r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:   if (i_start) n_state = CS_NORM;
            CS_NORM:   if (w_norm_last) n_state = CS_CONE;
            CS_CONE:   if (r_phase && r_k == CK_RNG) n_state = CS_DECIDE;
            CS_DECIDE: n_state = CS_IDLE;
            default:   n_state = CS_IDLE;
        endcase
    end

    // Each step issues one product in phase 0 and folds it in during phase 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (r_state == CS_NORM || r_state == CS_CONE) begin
            r_phase <= !r_phase;
        end else begin
            r_phase <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CS_IDLE && i_start) begin
            r_hn <= i_nbr_shape;
            r_t  <= 1'b0;
            r_j  <= '0;
            r_c  <= '0;
            r_k  <= CK_DOT0;
            for (int i = 0; i < DIMS; i++) begin
                r_r[i]   <= w_diff[i];
                r_bsg[i] <= w_diff[i][32];
                r_bm[i]  <= w_diff[i][32] ? 33'(-w_diff[i]) : 33'(w_diff[i]);
                r_asg[i] <= i_self_m1[i][31];
                r_am[i]  <= i_self_m1[i][31] ? 32'(-i_self_m1[i]) : 32'(i_self_m1[i]);
            end
        end else begin
            // Both vectors are brought below 2^15 one bit a cycle, alongside the norms.
            for (int i = 0; i < DIMS; i++) begin
                if (w_a_big) r_am[i] <= r_am[i] >> 1;
                if (w_b_big) r_bm[i] <= r_bm[i] >> 1;
            end
            if (r_state == CS_NORM && r_phase) begin
                if (r_c == 2'(DIMS)) begin
                    r_tot[r_t] <= ((r_j == 2'd0) ? 64'd0 : r_tot[r_t]) + w_p[63:0];
                    r_c <= '0;
                    if (r_j == 2'(DIMS - 1)) begin
                        r_j <= '0;
                        r_t <= 1'b1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end else begin
                    r_acc <= ((r_c == 2'd0) ? 67'sd0 : r_acc) + w_p[66:0];
                    r_c <= r_c + 2'd1;
                end
            end
            if (r_state == CS_CONE && r_phase) begin
                case (r_k)
                    CK_DOT0:                r_d <= w_p[32:0];
                    CK_DOT1, CK_DOT2:       r_d <= r_d + w_p[32:0];
                    CK_MM0:                 r_mm <= w_p[31:0];
                    CK_MM1, CK_MM2:         r_mm <= r_mm + w_p[31:0];
                    CK_RR0:                 r_rr <= w_p[31:0];
                    CK_RR1, CK_RR2:         r_rr <= r_rr + w_p[31:0];
                    CK_DD:                  r_ll <= w_p[63:0];
                    CK_CC:                  r_c2 <= w_p[32:0];
                    CK_CMM:                 r_cmm <= w_p[63:0];
                    CK_PLO:                 r_plo <= w_p[63:0];
                    CK_PHI:                 r_rhs <= {w_p[63:0], 32'd0} + {32'd0, r_plo};
                    CK_RNG:                 r_rng2 <= w_p[61:0];
                    default:                r_d <= r_d;
                endcase
                if (r_k != CK_RNG) r_k <= t_cone_step'(r_k + 4'd1);
            end
        end
    end

    // Cone test on squares: d^2 * 2^30 against cos^2 * |m1|^2 * |r|^2.
    always_comb begin
        w_lhs = {2'b00, r_ll, 30'd0};
        if (r_mm == 32'd0 || r_rr == 32'd0) begin
            w_cone = (i_cos <= 17'sd0);
        end else if (i_cos > 17'sd0) begin
            w_cone = (r_d > 33'sd0) && (w_lhs >= r_rhs);
        end else begin
            w_cone = (r_d >= 33'sd0) || (w_lhs <= r_rhs);
        end
        w_emin     = (r_tot[0] < r_tot[1]) ? r_tot[0] : r_tot[1];
        w_range_ok = w_emin < {2'b00, r_rng2};
        o_status.busy = (r_state != CS_IDLE);
        o_status.done = (r_state == CS_DECIDE);
        o_status.hit  = w_cone && w_range_ok;
    end

endmodule
`default_nettype wire

// ===== rtl/particle_surface_detect.sv =====
// Top level of the particle surface detector: operation decode, particle state and ports.
// Classifies one particle at a time. Operations 0 (position and tensor), 1 (moments, clears
// the found flag) and 3 (finish, one surface_flag result) never make the block busy. Operation 2
// (neighbor) keeps the block busy after its transfer: 24 multiplies for the two scaled
// distances and 15 for the cone and range tests, each issued and then folded in on the single
// shared multiplier, plus a decision state. The result of a finish is held in an output register;
// while that result waits under a stalled output, the input is stalled as well.
`timescale 1ns / 1ps
`default_nettype none
module particle_surface_detect (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [31:0] i_sym_xx,
    input  wire logic signed [31:0] i_sym_xy,
    input  wire logic signed [31:0] i_sym_xz,
    input  wire logic signed [31:0] i_sym_yy,
    input  wire logic signed [31:0] i_sym_yz,
    input  wire logic signed [31:0] i_sym_zz,
    input  wire logic signed [31:0] i_scalar_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_surface_flag,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import psd_pkg::*;

    logic [30:0]        r_threshold;
    logic [30:0]        r_range;
    logic signed [16:0] r_cos;
    t_vec3              r_pos;
    t_sym6              r_shape;
    t_word              r_mass;
    t_vec3              r_m1;
    logic               r_found;
    logic               r_out_valid;
    logic               r_out_flag;

    t_vec3              w_vec;
    t_sym6              w_sym;
    t_psd_status        w_status;
    logic               w_in_acc;
    logic signed [32:0] w_dev;
    logic [32:0]        w_dev_mag;
    logic               w_surface;

    assign w_vec[0] = i_vec_x;
    assign w_vec[1] = i_vec_y;
    assign w_vec[2] = i_vec_z;
    assign w_sym[0] = i_sym_xx;
    assign w_sym[1] = i_sym_xy;
    assign w_sym[2] = i_sym_xz;
    assign w_sym[3] = i_sym_yy;
    assign w_sym[4] = i_sym_yz;
    assign w_sym[5] = i_sym_zz;

    assign o_in_stall     = w_status.busy || (r_out_valid && i_out_stall);
    assign w_in_acc       = i_in_valid && !o_in_stall;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_surface_flag = r_out_flag;

    assign w_dev     = 33'(r_mass) - ONE_Q16;
    assign w_dev_mag = w_dev[32] ? 33'(-w_dev) : 33'(w_dev);
    assign w_surface = (w_dev_mag > {2'b00, r_threshold}) && !r_found;

    psd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_in_acc && (t_op'(i_operation) == OP_NEIGHBOR)),
        .i_nbr_pos    (w_vec),
        .i_nbr_shape  (w_sym),
        .i_self_pos   (r_pos),
        .i_self_shape (r_shape),
        .i_self_m1    (r_m1),
        .i_range      (r_range),
        .i_cos        (r_cos),
        .o_status     (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_range     <= RANGE_RESET;
            r_cos       <= COS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_THRESHOLD: r_threshold <= i_cfg_data[30:0];
                REG_RANGE:     r_range     <= i_cfg_data[30:0];
                REG_COS_SWEEP: r_cos       <= $signed(i_cfg_data[16:0]);
                default:       r_cos       <= r_cos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_shape <= '0;
            r_mass  <= '0;
            r_m1    <= '0;
            r_found <= 1'b0;
        end else begin
            if (w_status.done && w_status.hit) r_found <= 1'b1;
            if (w_in_acc) begin
                unique case (t_op'(i_operation))
                    OP_SELF_SHAPE: begin
                        r_pos   <= w_vec;
                        r_shape <= w_sym;
                    end
                    OP_SELF_MOMENT: begin
                        r_m1    <= w_vec;
                        r_mass  <= i_scalar_value;
                        r_found <= 1'b0;
                    end
                    OP_NEIGHBOR: r_found <= r_found;
                    OP_FINISH:   r_found <= r_found;
                    default:     r_found <= r_found;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && (t_op'(i_operation) == OP_FINISH)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (t_op'(i_operation) == OP_FINISH)) begin
            r_out_flag <= w_surface;
        end
    end

    a_nbr_starts_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_operation == OP_NEIGHBOR) |=> w_status.busy)
        else $error("neighbor transfer did not start the sequencer");

    a_done_frees_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |=> !w_status.busy)
        else $error("sequencer still busy after its decision");

    a_found_from_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(w_status.done && w_status.hit))
        else $error("found flag set without a neighbor hit");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_in_acc && i_operation == OP_FINISH))
        else $error("result shown without a finish transfer");

endmodule
`default_nettype wire

// ===== tb/particle_surface_detect_tb.sv =====
// Self-checking testbench for the particle surface detector with a predicting scoreboard.
`timescale 1ns / 1ps
module particle_surface_detect_tb;
    import psd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 122;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Predicts surface flags from accepted transfers and checks the results.
    class surface_scoreboard;
        longint unsigned thr;
        longint unsigned rng;
        longint          cosw;
        longint          pos[3];
        longint          shape[6];
        longint          m0;
        longint          m1[3];
        bit              found;
        bit              flags_due[$];
        int              errors;
        int              finishes;
        int              hits;

        function new();
            thr = THRESHOLD_RESET;
            rng = RANGE_RESET;
            cosw = COS_RESET;
            foreach (pos[i]) pos[i] = 0;
            foreach (m1[i]) m1[i] = 0;
            foreach (shape[i]) shape[i] = 0;
            m0 = 0;
            found = 0;
            errors = 0;
            finishes = 0;
            hits = 0;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_THRESHOLD: thr = data[30:0];
                REG_RANGE:     rng = data[30:0];
                REG_COS_SWEEP: cosw = longint'($signed(data[16:0]));
                default: ;
            endcase
        endfunction

        function longint unsigned eta_sq(longint h[6], longint r[3]);
            int sidx[3][3];
            longint unsigned total;
            longint high, low, rl, rh, hv;
            longint unsigned m;
            sidx = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
            total = 0;
            for (int row = 0; row < 3; row++) begin
                high = 0;
                low = 0;
                for (int col = 0; col < 3; col++) begin
                    hv = h[sidx[row][col]];
                    rl = r[col] & 64'hFFFF;
                    rh = (r[col] - rl) >>> 16;
                    high += hv * rh;
                    low += hv * rl;
                end
                m = mag(high + (low >>> 16));
                if (m > 64'h8000_0000) m = 64'h8000_0000;
                total += m * m;
            end
            return total;
        endfunction

        // Shift every component right until the largest fits below 2^15, keeping signs.
        function void shrink(longint v[3], output longint o[3]);
            longint unsigned big;
            int s;
            big = 0;
            s = 0;
            for (int i = 0; i < 3; i++) if (mag(v[i]) > big) big = mag(v[i]);
            while ((big >> s) >= 64'd32768) s++;
            for (int i = 0; i < 3; i++)
                o[i] = v[i] < 0 ? -longint'(mag(v[i]) >> s) : longint'(mag(v[i]) >> s);
        endfunction

        function bit in_cone(longint r[3]);
            longint a[3], b[3];
            longint d;
            longint unsigned mm, rr, dm, c2;
            logic [127:0] lhs, rhs;
            shrink(m1, a);
            shrink(r, b);
            d = 0;
            mm = 0;
            rr = 0;
            for (int i = 0; i < 3; i++) begin
                d += a[i] * b[i];
                mm += a[i] * a[i];
                rr += b[i] * b[i];
            end
            if (mm == 0 || rr == 0) return cosw <= 0;
            dm = mag(d);
            c2 = mag(cosw) * mag(cosw);
            lhs = 128'(dm * dm) << 30;
            rhs = 128'(c2);
            rhs = rhs * mm;
            rhs = rhs * rr;
            if (cosw > 0) return d > 0 && lhs >= rhs;
            if (d >= 0) return 1;
            return lhs <= rhs;
        endfunction

        function void note_item(t_op op, t_vec3 v, t_sym6 s, t_word m);
            longint r[3], h[6];
            longint unsigned ei, ej, emin;
            case (op)
                OP_SELF_SHAPE: begin
                    for (int i = 0; i < 3; i++) pos[i] = v[i];
                    for (int i = 0; i < 6; i++) shape[i] = s[i];
                end
                OP_SELF_MOMENT: begin
                    for (int i = 0; i < 3; i++) m1[i] = v[i];
                    m0 = m;
                    found = 0;
                end
                OP_NEIGHBOR: begin
                    for (int i = 0; i < 3; i++) r[i] = longint'(v[i]) - pos[i];
                    for (int i = 0; i < 6; i++) h[i] = s[i];
                    ei = eta_sq(shape, r);
                    ej = eta_sq(h, r);
                    emin = ei < ej ? ei : ej;
                    if (in_cone(r) && emin < rng * rng) begin
                        found = 1;
                        hits++;
                    end
                end
                default: begin
                    flags_due.push_back(mag(m0 - 65536) > thr && !found);
                    finishes++;
                end
            endcase
        endfunction

        function void check_flag(logic flag);
            bit want;
            if (flags_due.size() == 0) begin
                $error("surface_flag result %0b arrived with none expected", flag);
                errors++;
                return;
            end
            want = flags_due.pop_front();
            if (flag !== want) begin
                $error("surface_flag mismatch: expected %0b actual %0b", want, flag);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    t_vec3              vec;
    t_sym6              sym;
    t_word              i_scalar_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_surface_flag;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    surface_scoreboard sb;
    int in_idle;
    int out_idle;
    int quiet_cycles;
    int items_sent;

    particle_surface_detect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation),
        .i_vec_x(vec[0]), .i_vec_y(vec[1]), .i_vec_z(vec[2]),
        .i_sym_xx(sym[0]), .i_sym_xy(sym[1]), .i_sym_xz(sym[2]),
        .i_sym_yy(sym[3]), .i_sym_yz(sym[4]), .i_sym_zz(sym[5]),
        .i_scalar_value(i_scalar_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_surface_flag(o_surface_flag),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_flag(o_surface_flag);
        i_out_stall <= ($urandom_range(99) < out_idle);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_word any_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(262143)) - 131072;
            2: case ($urandom_range(4))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 0;
                   3: return -1;
                   default: return 65536;
               endcase
            default: return $signed($urandom_range(33554431)) - 16777216;
        endcase
    endfunction

    function automatic t_word near(t_word center, int spread);
        return center + $signed($urandom_range(2 * spread)) - spread;
    endfunction

    task automatic send_item(t_op op, t_vec3 v, t_sym6 s, t_word m);
        while ($urandom_range(99) < in_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        vec <= v;
        sym <= s;
        i_scalar_value <= m;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(op, v, s, m);
        items_sent++;
    endtask

    // Hold off the sender until every flag is back and the last neighbor has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.flags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(t_op op);
        t_vec3 v;
        t_sym6 s;
        for (int i = 0; i < 3; i++) v[i] = any_word();
        for (int i = 0; i < 6; i++) s[i] = any_word();
        send_item(op, v, s, any_word());
    endtask

    // One particle: self load, moments, a few neighbors around it, then finish.
    task automatic send_particle();
        t_vec3 p, v;
        t_sym6 s, ns;
        t_word m;
        int n;
        for (int i = 0; i < 3; i++) p[i] = near(0, 1 << 20);
        for (int i = 0; i < 6; i++)
            s[i] = (i == 0 || i == 3 || i == 5) ? near(65536, 40000) : near(0, 16000);
        send_item(OP_SELF_SHAPE, p, s, 0);
        for (int i = 0; i < 3; i++) v[i] = ($urandom_range(5) == 0) ? 0 : near(0, 1 << 18);
        m = ($urandom_range(1)) ? near(65536, 8000) : any_word();
        send_item(OP_SELF_MOMENT, v, s, m);
        n = $urandom_range(4);
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 3; i++) v[i] = near(p[i], 100000);
            for (int i = 0; i < 6; i++)
                ns[i] = (i == 0 || i == 3 || i == 5) ? near(65536, 40000) : near(0, 16000);
            send_item(OP_NEIGHBOR, v, ns, any_word());
        end
        send_item(OP_FINISH, p, s, m);
    endtask

    task automatic run_directed();
        t_vec3 z3, hi3, lo3;
        t_sym6 z6, hi6, lo6, id6;
        z3 = '0;
        z6 = '0;
        hi3 = {3{32'h7FFF_FFFF}};
        lo3 = {3{32'h8000_0000}};
        hi6 = {6{32'h7FFF_FFFF}};
        lo6 = {6{32'h8000_0000}};
        id6 = {32'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536};
        send_item(OP_FINISH, z3, z6, 0);
        send_item(OP_NEIGHBOR, z3, z6, 0);
        send_item(OP_SELF_SHAPE, z3, id6, 0);
        send_item(OP_SELF_MOMENT, z3, z6, 32'd65536);
        // A neighbor on top of the particle has a zero offset.
        send_item(OP_NEIGHBOR, z3, id6, 0);
        send_item(OP_FINISH, z3, z6, 0);
        send_item(OP_SELF_MOMENT, {32'd0, 32'd0, 32'd65536}, z6, 32'h8000_0000);
        send_item(OP_NEIGHBOR, {32'd0, 32'd0, 32'd30000}, id6, 0);
        send_item(OP_FINISH, z3, z6, 0);
        send_item(OP_NEIGHBOR, hi3, lo6, -1);
        send_item(OP_FINISH, z3, z6, 0);
        send_item(OP_SELF_MOMENT, lo3, z6, 32'h7FFF_FFFF);
        send_item(OP_SELF_SHAPE, hi3, hi6, -1);
        send_item(OP_NEIGHBOR, lo3, hi6, 0);
        send_item(OP_NEIGHBOR, hi3, lo6, 0);
        send_item(OP_SELF_SHAPE, lo3, lo6, 0);
        send_item(OP_NEIGHBOR, hi3, hi6, 0);
        send_item(OP_FINISH, z3, z6, 0);
        send_item(OP_FINISH, hi3, hi6, -1);
        send_item(OP_SELF_MOMENT, hi3, hi6, 32'd65536 + 32'd6554);
        send_item(OP_FINISH, z3, z6, 0);
    endtask

    initial begin
        logic [30:0] thr_set[PHASES];
        logic [30:0] rng_set[PHASES];
        logic [16:0] cos_set[PHASES];
        int count;
        thr_set = '{31'd6554, 31'd0, 31'h7FFF_FFFF, 31'd100000, 31'd1, 31'd3000};
        rng_set = '{31'd65536, 31'h7FFF_FFFF, 31'd0, 31'd200000, 31'd131072, 31'd40000};
        cos_set = '{17'sd23170, 17'sd32768, -17'sd32768, 17'h0FFFF, 17'h10000, 17'sd0};
        sb = new();
        in_idle = 36;
        out_idle = 59;
        quiet_cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_SELF_SHAPE;
        vec = '0;
        sym = '0;
        i_scalar_value = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_THRESHOLD;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                in_idle = 59;
                out_idle = 36;
            end else if (ph == 4) begin
                in_idle = 0;
                out_idle = 0;
            end
            drain();
            write_reg(REG_THRESHOLD, {1'($urandom_range(1)), thr_set[ph]});
            write_reg(REG_RANGE, {1'($urandom_range(1)), rng_set[ph]});
            write_reg(REG_COS_SWEEP, {15'($urandom), cos_set[ph]});
            // The unused index names no register and must leave everything as it was.
            write_reg(REG_UNUSED, $urandom);
            count = items_sent;
            while (items_sent - count < PHASE_ITEMS) begin
                if ($urandom_range(99) < 85) send_particle();
                else send_random(t_op'($urandom_range(3)));
            end
        end
        drain();
        $display("Sent %0d items over %0d register settings; %0d finishes checked.",
                 items_sent, PHASES + 1, sb.finishes);
        $display("Neighbors that set the found flag: %0d; mismatches: %0d.",
                 sb.hits, sb.errors);
        if (sb.errors == 0 && sb.flags_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
